[rtl/utt_pkg.sv]
// Shared types and constants for the tick-driven 8N1 serial transceiver.
// No dependencies; used by the top level, utt_core and the testbench.
package utt_pkg;

    localparam int unsigned PeriodWidth  = 16;
    localparam int unsigned TxFrameWidth = 11;
    localparam int unsigned RxFrameWidth = 10;
    localparam int unsigned RxCountWidth = 4;

    localparam logic [15:0] PeriodReset = 16'd434;
    localparam logic [3:0]  RxLastBit   = 4'd9;      // count before the stop sample

    // APB register indexes (word address)
    localparam logic RegBitPeriod = 1'b0;

    typedef struct packed {
        logic       rx_level;
        logic       send_request;
        logic [7:0] send_byte;
        logic       take_byte;
    } t_item;

    typedef struct packed {
        logic       tx_line;
        logic       tx_busy;
        logic       rx_ready;
        logic [7:0] rx_byte;
    } t_result;

endpackage

[rtl/uart_8n1_tick_transceiver_top.sv]
// Top level of the tick-driven 8N1 serial transceiver: APB register,
// input and result registers around utt_core. Depends on utt_pkg, utt_core.
//
// Usage:
//  - Input channel (i_in_valid / o_in_stall): one beat is one bit-timer tick,
//    carrying the receive line level, a send request with its byte and a
//    take strobe that consumes the held received byte.
//  - Output channel (o_out_valid / i_out_stall): one beat per input beat with
//    transmit line level, transmit busy, receive ready and the held byte,
//    all taken after that tick's update.
//  - APB port: one register, bit_period at byte address 0 (bit-timer ticks per
//    serial bit, reset 434). Write it only while no beat is in flight.
//  - Path: an accepted beat waits in the input register until the result
//    register is free or draining, then moves into it; its result is
//    visible from then on. One beat per cycle sustained while i_out_stall is low.
//  - The rate is set by the single state update per tick in utt_core.
//  - Stall: while the result register is held, a buffered input beat waits
//    there and o_in_stall stays high until the result beat drains.
//  - Reset (synchronous, active low): both registers empty, line idle high,
//    transmitter and receiver idle, bit_period back to 434.
module uart_8n1_tick_transceiver_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input beats
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_rx_level,
    input  logic        i_send_request,
    input  logic [7:0]  i_send_byte,
    input  logic        i_take_byte,
    // result beats
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_tx_line,
    output logic        o_tx_busy,
    output logic        o_rx_ready,
    output logic [7:0]  o_rx_byte,
    // APB
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [utt_pkg::PeriodWidth-1:0] r_bit_period;
    logic                            r_in_valid;
    utt_pkg::t_item                  r_item;
    logic                            r_out_valid;
    utt_pkg::t_result                r_out;
    utt_pkg::t_result                core_next;
    logic                            advance;
    logic                            in_accept;
    logic                            reg_hit;

    // Config register; word index is paddr[2], low bits are byte offset
    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == utt_pkg::RegBitPeriod);
    assign prdata  = reg_hit ? {16'd0, r_bit_period} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period <= utt_pkg::PeriodReset;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_bit_period <= pwdata[15:0];
        end
    end

    // Buffered tick moves on whenever the result register is free or drained
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item.rx_level     <= i_rx_level;
            r_item.send_request <= i_send_request;
            r_item.send_byte    <= i_send_byte;
            r_item.take_byte    <= i_take_byte;
        end
    end

    utt_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (advance),
        .i_bit_period (r_bit_period),
        .i_item       (r_item),
        .o_next       (core_next)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_tx_line   = r_out.tx_line;
    assign o_tx_busy   = r_out.tx_busy;
    assign o_rx_ready  = r_out.rx_ready;
    assign o_rx_byte   = r_out.rx_byte;

endmodule

[rtl/utt_core.sv]
// Bit timer, transmit shifter and receive sampler of the serial transceiver.
// Depends on utt_pkg. State advances once per enabled tick.
module utt_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic [utt_pkg::PeriodWidth-1:0]    i_bit_period,
    input  utt_pkg::t_item                     i_item,
    output utt_pkg::t_result                   o_next
);

    logic [utt_pkg::PeriodWidth-1:0]  r_tick_count, n_tick_count;
    logic [utt_pkg::TxFrameWidth-1:0] r_tx_shift, n_tx_shift;
    logic                             r_tx_out, n_tx_out;
    logic                             r_rx_active, n_rx_active;
    logic                             r_rx_prev, n_rx_prev;
    logic [utt_pkg::PeriodWidth-1:0]  r_rx_point, n_rx_point;
    logic [utt_pkg::RxFrameWidth-1:0] r_rx_shift, n_rx_shift;
    logic [utt_pkg::RxCountWidth-1:0] r_rx_count, n_rx_count;
    logic [7:0]                       r_rx_hold, n_rx_hold;
    logic                             r_rx_full, n_rx_full;

    logic [utt_pkg::PeriodWidth:0]    tick_inc;
    logic [utt_pkg::PeriodWidth:0]    point_sum;
    logic                             wrap;
    logic                             hit;
    logic [utt_pkg::RxFrameWidth-1:0] rx_data;

    assign tick_inc  = {1'b0, r_tick_count} + 17'd1;
    assign wrap      = tick_inc >= {1'b0, i_bit_period};
    assign hit       = (r_tick_count == r_rx_point) || (wrap && (r_rx_point > r_tick_count));
    assign rx_data   = {i_item.rx_level, r_rx_shift[utt_pkg::RxFrameWidth-1:1]};
    assign point_sum = {1'b0, r_tick_count} + {2'b00, i_bit_period[15:1]};

    always_comb begin
        n_tick_count = wrap ? '0 : tick_inc[utt_pkg::PeriodWidth-1:0];

        // transmitter: shift at each wrap, load only when idle
        n_tx_shift = r_tx_shift;
        n_tx_out   = r_tx_out;
        if (r_tx_shift != '0) begin
            if (wrap) begin
                n_tx_out   = r_tx_shift[0];
                n_tx_shift = r_tx_shift >> 1;
            end
        end else if (i_item.send_request) begin
            n_tx_shift = {2'b11, i_item.send_byte, 1'b0};
        end

        // receiver
        n_rx_active = r_rx_active;
        n_rx_point  = r_rx_point;
        n_rx_shift  = r_rx_shift;
        n_rx_count  = r_rx_count;
        n_rx_hold   = r_rx_hold;
        n_rx_full   = r_rx_full && !i_item.take_byte;
        if (r_rx_active) begin
            if (hit) begin
                n_rx_shift = rx_data;
                if (r_rx_count >= utt_pkg::RxLastBit) begin
                    // stop sample taken: keep the byte only on a clean frame
                    if (!rx_data[0] && rx_data[9]) begin
                        n_rx_hold = rx_data[8:1];
                        n_rx_full = 1'b1;
                    end
                    n_rx_active = 1'b0;
                    n_rx_count  = '0;
                end else begin
                    n_rx_count = r_rx_count + 4'd1;
                end
            end
        end else if (r_rx_prev && !i_item.rx_level) begin
            if (point_sum >= {1'b0, i_bit_period}) begin
                n_rx_point = point_sum[15:0] - i_bit_period;
            end else begin
                n_rx_point = point_sum[15:0];
            end
            n_rx_active = 1'b1;
            n_rx_shift  = '0;
            n_rx_count  = '0;
        end
        n_rx_prev = i_item.rx_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count <= '0;
            r_tx_shift   <= '0;
            r_tx_out     <= 1'b1;
            r_rx_active  <= 1'b0;
            r_rx_prev    <= 1'b1;
            r_rx_point   <= '0;
            r_rx_shift   <= '0;
            r_rx_count   <= '0;
            r_rx_hold    <= '0;
            r_rx_full    <= 1'b0;
        end else if (i_en) begin
            r_tick_count <= n_tick_count;
            r_tx_shift   <= n_tx_shift;
            r_tx_out     <= n_tx_out;
            r_rx_active  <= n_rx_active;
            r_rx_prev    <= n_rx_prev;
            r_rx_point   <= n_rx_point;
            r_rx_shift   <= n_rx_shift;
            r_rx_count   <= n_rx_count;
            r_rx_hold    <= n_rx_hold;
            r_rx_full    <= n_rx_full;
        end
    end

    assign o_next.tx_line  = n_tx_out;
    assign o_next.tx_busy  = (n_tx_shift != '0);
    assign o_next.rx_ready = n_rx_full;
    assign o_next.rx_byte  = n_rx_hold;

endmodule

[rtl/utt_checker.sv]
// Port-level checks for the serial transceiver top level, with its bind.
// Depends on uart_8n1_tick_transceiver_top port names only.
module utt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_tx_line,
    input logic       o_tx_busy,
    input logic       o_rx_ready,
    input logic [7:0] o_rx_byte
);

    logic       r_seen;
    logic [7:0] r_last_byte;
    logic       out_beat;

    assign out_beat = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= 1'b0;
            r_last_byte <= '0;
        end else if (out_beat) begin
            r_seen      <= 1'b1;
            r_last_byte <= o_rx_byte;
        end
    end

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid &&
            $stable({o_tx_line, o_tx_busy, o_rx_ready, o_rx_byte}))
        else $error("result changed while stalled");

    // idle transmitter drives the line high
    a_idle_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_tx_busy |-> o_tx_line)
        else $error("tx line low while transmitter idle");

    // input side only backs up behind a full result register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with result side free");

    // a new received byte always comes with ready set
    a_byte_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat && r_seen && (o_rx_byte != r_last_byte) |-> o_rx_ready)
        else $error("received byte changed without ready");

endmodule

bind uart_8n1_tick_transceiver_top utt_checker u_utt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_tx_line   (o_tx_line),
    .o_tx_busy   (o_tx_busy),
    .o_rx_ready  (o_rx_ready),
    .o_rx_byte   (o_rx_byte)
);

[tb/sv/utt_line_checker.sv]
// Checker for the 8N1 tick transceiver: mirrors the bit timer, transmitter and
// receiver per accepted input beat and compares every result beat against it.
// Depends on utt_pkg for the beat types and register constants.
module utt_line_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic              i_rx_level,
    input  logic              i_send_request,
    input  logic [7:0]        i_send_byte,
    input  logic              i_take_byte,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic              i_tx_line,
    input  logic              i_tx_busy,
    input  logic              i_rx_ready,
    input  logic [7:0]        i_rx_byte,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,
    output int unsigned       o_pending,
    output int unsigned       o_fail_count
);

    logic [15:0]  period_q;
    logic [15:0]  tick_cnt;
    logic [10:0]  tx_frame;
    logic         tx_lvl;
    logic         rx_busy;
    logic         rx_last;
    logic [15:0]  rx_spot;
    logic [9:0]   rx_bits;
    logic [3:0]   rx_cnt;
    logic [7:0]   rx_held;
    logic         rx_have;

    utt_pkg::t_result pending_line_states[$];
    int unsigned      fails = 0;

    // one bit-timer tick; all decisions use the state from the start of the tick
    function automatic utt_pkg::t_result next_line_state(utt_pkg::t_item beat);
        utt_pkg::t_result r;
        logic        bit_end;
        logic [9:0]  word;
        logic [16:0] spot;
        bit_end = (32'(tick_cnt) + 32'd1) >= 32'(period_q);

        if (tx_frame != '0) begin
            if (bit_end) begin
                tx_lvl   = tx_frame[0];
                tx_frame = tx_frame >> 1;
            end
        end else if (beat.send_request) begin
            tx_frame = {2'b11, beat.send_byte, 1'b0};
        end

        if (beat.take_byte)
            rx_have = 1'b0;
        if (rx_busy) begin
            // late sample point (period shrunk) is caught on the wrap tick
            if (tick_cnt == rx_spot || (bit_end && rx_spot > tick_cnt)) begin
                word = {beat.rx_level, rx_bits[9:1]};
                if (5'(rx_cnt) + 5'd1 >= 5'(utt_pkg::RxFrameWidth)) begin
                    if (!word[0] && word[9]) begin
                        rx_held = word[8:1];
                        rx_have = 1'b1;
                    end
                    rx_busy = 1'b0;
                    rx_cnt  = '0;
                end else begin
                    rx_cnt = rx_cnt + 4'd1;
                end
                rx_bits = word;
            end
        end else if (rx_last && !beat.rx_level) begin
            spot = 17'(tick_cnt) + 17'(period_q >> 1);
            if (spot >= 17'(period_q))
                spot = spot - 17'(period_q);
            rx_spot = spot[15:0];
            rx_busy = 1'b1;
            rx_bits = '0;
            rx_cnt  = '0;
        end
        rx_last  = beat.rx_level;
        tick_cnt = bit_end ? 16'd0 : tick_cnt + 16'd1;

        r.tx_line  = tx_lvl;
        r.tx_busy  = (tx_frame != '0);
        r.rx_ready = rx_have;
        r.rx_byte  = rx_held;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        utt_pkg::t_result want;
        utt_pkg::t_item   beat;
        if (!i_rst_n) begin
            period_q = utt_pkg::PeriodReset;
            tick_cnt = '0;
            tx_frame = '0;
            tx_lvl   = 1'b1;
            rx_busy  = 1'b0;
            rx_last  = 1'b1;
            rx_spot  = '0;
            rx_bits  = '0;
            rx_cnt   = '0;
            rx_held  = '0;
            rx_have  = 1'b0;
            pending_line_states.delete();
        end else begin
            if (psel && penable && pwrite && pready &&
                (paddr >> 2) == utt_pkg::RegBitPeriod)
                period_q = pwdata[15:0];

            if (i_out_valid && !i_out_stall) begin
                if (pending_line_states.size() == 0) begin
                    $error("result beat with no expected line state waiting");
                    fails++;
                end else begin
                    want = pending_line_states.pop_front();
                    check_field("tx_line", 8'(want.tx_line), 8'(i_tx_line));
                    check_field("tx_busy", 8'(want.tx_busy), 8'(i_tx_busy));
                    check_field("rx_ready", 8'(want.rx_ready), 8'(i_rx_ready));
                    check_field("rx_byte", want.rx_byte, i_rx_byte);
                end
            end

            if (i_in_valid && !i_in_stall) begin
                beat = '{rx_level: i_rx_level, send_request: i_send_request,
                         send_byte: i_send_byte, take_byte: i_take_byte};
                pending_line_states.push_back(next_line_state(beat));
            end
        end
        o_pending    <= pending_line_states.size();
        o_fail_count <= fails;
    end

endmodule

[tb/sv/uart_8n1_tick_transceiver_top_test.sv]
// Stimulus and verdict for the 8N1 tick transceiver: serial frames on the
// receive line, send and take strobes, bit period changes over APB.
// Depends on utt_pkg, uart_8n1_tick_transceiver_top and utt_line_checker.
module uart_8n1_tick_transceiver_top_test;

    localparam int unsigned CycleLimit  = 200000;
    localparam int unsigned HoldCycles  = 300;   // long receiver hold-off
    localparam int unsigned RandomTicks = 600;
    localparam logic [2:0]  PeriodAddr  = {utt_pkg::RegBitPeriod, 2'b00};
    localparam logic [2:0]  SpareAddr   = {~utt_pkg::RegBitPeriod, 2'b00};  // no register here

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        i_rx_level     = 1'b1;
    logic        i_send_request = 1'b0;
    logic [7:0]  i_send_byte    = '0;
    logic        i_take_byte    = 1'b0;
    logic        i_out_stall    = 1'b0;
    logic        psel           = 1'b0;
    logic        penable        = 1'b0;
    logic        pwrite         = 1'b0;
    logic [2:0]  paddr          = '0;
    logic [31:0] pwdata         = '0;
    logic        pressure_on    = 1'b0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_tx_line;
    logic        o_tx_busy;
    logic        o_rx_ready;
    logic [7:0]  o_rx_byte;
    logic [31:0] prdata;
    logic        pready;

    int unsigned pending;
    int unsigned fail_count;

    // stimulus state
    int unsigned cur_period  = utt_pkg::PeriodReset;
    int unsigned burst_left  = 0;
    int unsigned ticks_sent  = 0;
    int unsigned take_odds   = 4;   // 0: never take
    int unsigned send_odds   = 3;
    logic        line_plan[$];      // receive line level, one entry per tick

    // receiver pacing state, owned by the stall process; cycle_count belongs to the hang guard
    int unsigned hold_count   = 0;
    int unsigned stall_odds   = 0;
    int unsigned pattern_left = 0;
    int unsigned cycle_count  = 0;

    always #2 i_clk = ~i_clk;

    uart_8n1_tick_transceiver_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_rx_level     (i_rx_level),
        .i_send_request (i_send_request),
        .i_send_byte    (i_send_byte),
        .i_take_byte    (i_take_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_tx_line      (o_tx_line),
        .o_tx_busy      (o_tx_busy),
        .o_rx_ready     (o_rx_ready),
        .o_rx_byte      (o_rx_byte),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    utt_line_checker u_line_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_rx_level     (i_rx_level),
        .i_send_request (i_send_request),
        .i_send_byte    (i_send_byte),
        .i_take_byte    (i_take_byte),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_tx_line      (o_tx_line),
        .i_tx_busy      (o_tx_busy),
        .i_rx_ready     (o_rx_ready),
        .i_rx_byte      (o_rx_byte),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .o_pending      (pending),
        .o_fail_count   (fail_count)
    );

    // Result side pacing. Density is redrawn when pattern_left runs out;
    // density 0 gives stall-free stretches, 3 stalls at odds of 3 in 4.
    // Once the stimulus raises pressure_on, stall stays high until
    // hold_count hits HoldCycles: both registers fill, o_in_stall has to rise.
    always @(posedge i_clk) begin
        if (pressure_on && hold_count < HoldCycles) begin
            i_out_stall <= 1'b1;
            hold_count++;
        end else begin
            if (pattern_left == 0) begin
                stall_odds   = $urandom_range(0, 3);
                pattern_left = $urandom_range(8, 64);
            end else begin
                pattern_left--;
            end
            i_out_stall <= ($urandom_range(0, 3) < stall_odds);
        end
    end

    // hang guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // One beat = one bit-timer tick. Beats go out in bursts; between bursts
    // valid drops for a random gap (sometimes none). Payload holds until the
    // beat is taken.
    task automatic send_tick(input logic lvl, input logic req, input logic [7:0] data,
                             input logic take);
        int unsigned gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, 5);
            burst_left = $urandom_range(1, 32);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid     <= 1'b1;
        i_rx_level     <= lvl;
        i_send_request <= req;
        i_send_byte    <= data;
        i_take_byte    <= take;
        do @(posedge i_clk); while (o_in_stall);
        burst_left--;
    endtask

    // Queue up receive line levels for the current period: mostly clean
    // frames with random data, some with a low stop bit, some with a start
    // glitch no longer than half a bit, some plain noise. Very long periods
    // only get noise, a full frame would take too many ticks.
    task automatic plan_line();
        int unsigned kind;
        int unsigned p;
        logic [9:0]  frame;
        p    = cur_period;
        kind = $urandom_range(0, 19);
        if (p > 64 || kind == 0) begin
            repeat ($urandom_range(4, 24)) line_plan.push_back(1'($urandom_range(0, 1)));
        end else begin
            repeat ($urandom_range(1, 2 * p)) line_plan.push_back(1'b1);
            if (kind == 3) begin
                // start sample lands on the high level after the glitch
                repeat ($urandom_range(1, (p / 2 > 0) ? p / 2 : 1)) line_plan.push_back(1'b0);
                repeat (10 * p) line_plan.push_back(1'b1);
            end else begin
                frame = {1'b1, 8'($urandom), 1'b0};
                if (kind <= 2)
                    frame[9] = 1'b0;   // framing error
                for (int b = 0; b < 10; b++)
                    repeat (p) line_plan.push_back(frame[b]);
            end
        end
    endtask

    task automatic random_tick();
        logic take;
        if (line_plan.size() == 0)
            plan_line();
        take = (take_odds != 0) && ($urandom_range(1, take_odds) == 1);
        send_tick(line_plan.pop_front(), $urandom_range(1, send_odds) == 1,
                  8'($urandom), take);
        ticks_sent++;
    endtask

    // Stop offering and let every outstanding result drain. pending is
    // registered, so the loop checks it only after waiting at an edge.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // setup phase, access phase, then an idle phase on the bus
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_period(input int unsigned p);
        drain();
        apb_write(PeriodAddr, 32'(p));
        cur_period = p;
    endtask

    initial begin
        int unsigned period_plan[$];
        int unsigned phase;
        int unsigned p;
        int unsigned n;
        period_plan = '{3, 65535, 5, 24, 2, 4, 6, 8, 2};
        phase       = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, at the reset period: load a frame, a send while busy,
        // a falling edge with a take while nothing is held, and another
        // falling edge while the receiver is already busy.
        send_tick(1'b1, 1'b0, 8'h00, 1'b0);
        send_tick(1'b1, 1'b1, 8'hFF, 1'b0);
        send_tick(1'b1, 1'b1, 8'h00, 1'b0);
        send_tick(1'b0, 1'b0, 8'hAA, 1'b1);
        send_tick(1'b1, 1'b0, 8'h55, 1'b0);
        send_tick(1'b0, 1'b1, 8'h0F, 1'b0);

        // Write to the empty register slot, then drop to the shortest period
        // while the receiver is mid-frame: its sample point now lies beyond
        // the period, so sampling falls back to the wrap ticks. The line
        // stays low until a high stop level, with a take on that last tick.
        drain();
        apb_write(SpareAddr, 32'd5);
        set_period(2);
        for (int i = 0; i < 19; i++)
            send_tick(i == 18, i == 0, 8'h00, i == 18);

        // Random phases, each at a new bit period. Short periods dominate so
        // that many whole frames pass in both directions.
        while (ticks_sent < RandomTicks) begin
            if (phase < period_plan.size())
                p = period_plan[phase];
            else if ($urandom_range(0, 5) == 0)
                p = $urandom_range(9, 24);
            else
                p = $urandom_range(2, 8);
            set_period(p);
            line_plan.delete();
            case ($urandom_range(0, 3))
                0: take_odds = 0;      // unread bytes get overwritten
                1: take_odds = 40;
                2: take_odds = 4;
                default: take_odds = 2;
            endcase
            send_odds = $urandom_range(1, 10);
            if (phase == 3)
                pressure_on <= 1'b1;
            n = (p > 64) ? 30 : $urandom_range(40, 90);
            repeat (n) random_tick();
            phase++;
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
